// ===== design/xor_checked_frame_parser_top_defines.svh =====
// Assertion macros for the frame parser RTL, used by its top level.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef XOR_CHECKED_FRAME_PARSER_TOP_DEFINES_SVH
`define XOR_CHECKED_FRAME_PARSER_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define XCFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Implication checked in the next cycle.
`define XCFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

// ===== design/xcfp_pkg.sv =====
// Shared types and constants of the XOR-checked frame parser.
// No dependencies; used by the controller, the datapath and the top level.
package xcfp_pkg;

  localparam int RUN_LIMIT = 16;
  localparam int DEFAULT_PAYLOAD_DEPTH = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

  localparam logic [1:0] STAT_GOOD = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [1:0] STAT_BAD_CHECK = 2'd2;

  localparam logic [7:0] START_BYTE_RST = 8'd170;
  localparam logic [4:0] MAX_LEN_RST = 5'd15;

  typedef enum logic [2:0] {
    ST_START,
    ST_LEN,
    ST_CMD,
    ST_DATA,
    ST_CHECK,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_LEN_OK,
    OP_LEN_BAD,
    OP_CMD,
    OP_DATA,
    OP_GOOD_EMPTY,
    OP_GOOD_BURST,
    OP_CHECK_BAD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic is_start;
    logic len_too_big;
    logic len_zero;
    logic data_done;
    logic check_match;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/xcfp_ctrl.sv =====
// Frame parser controller: phase state machine and input handshake.
// Depends on xcfp_pkg; drives datapath operations from datapath status.
module xcfp_ctrl
  import xcfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output op_t      op,
  output state_t   state
);

  state_t state_next;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = OP_NONE;
    s_tready = 1'b0;
    acc = 1'b0;
    case (state)
      ST_START, ST_LEN, ST_CMD, ST_DATA, ST_CHECK: begin
        s_tready = stat.out_free;
        acc = s_tvalid && stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    case (state)
      ST_START: begin
        if (acc && stat.is_start) begin
          op = OP_START;
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        if (acc) begin
          if (stat.len_too_big) begin
            op = OP_LEN_BAD;
            state_next = ST_START;
          end else begin
            op = OP_LEN_OK;
            state_next = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (acc) begin
          op = OP_CMD;
          state_next = stat.len_zero ? ST_CHECK : ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          op = OP_DATA;
          if (stat.data_done) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (acc) begin
          if (!stat.check_match) begin
            op = OP_CHECK_BAD;
            state_next = ST_START;
          end else if (stat.len_zero) begin
            op = OP_GOOD_EMPTY;
            state_next = ST_START;
          end else begin
            op = OP_GOOD_BURST;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          op = OP_EMIT;
          state_next = stat.emit_last ? ST_START : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_START;
      end
    endcase
  end

endmodule

// ===== design/xcfp_dp.sv =====
// Frame parser datapath: config registers, frame fields, payload store,
// counters and the result register. Depends on xcfp_pkg.
module xcfp_dp
  import xcfp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            rx_byte,
  input  op_t                   op,
  output dp_stat_t              stat,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  localparam int STORE_DEPTH = (PAYLOAD_DEPTH < RUN_LIMIT) ? PAYLOAD_DEPTH : RUN_LIMIT;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [4:0] LEN_CAP = 5'(STORE_DEPTH);

  logic [7:0]  start_byte;
  logic [4:0]  max_len;
  logic [4:0]  frame_length;
  logic [7:0]  frame_command;
  logic [4:0]  payload_count;
  logic [7:0]  running_check;
  logic [15:0] good_frames;
  logic [15:0] bad_frames;
  logic [15:0] good_frames_next;
  logic [15:0] bad_frames_next;
  logic [3:0]  rd_idx;
  logic [7:0]  rd_data;
  logic [7:0]  store [STORE_DEPTH];
  logic [4:0]  limit;
  logic [4:0]  count_inc;
  logic        load;

  logic [1:0]  out_status;
  logic [7:0]  out_command;
  logic [4:0]  out_length;
  logic [3:0]  out_index;
  logic [7:0]  out_payload;
  logic        out_has_payload;
  logic [7:0]  out_check;
  logic        out_last;
  logic [15:0] out_good;
  logic [15:0] out_error;

  always_comb begin
    limit = (max_len < LEN_CAP) ? max_len : LEN_CAP;
    count_inc = payload_count + 5'd1;
    stat.out_free = !m_tvalid || m_tready;
    stat.is_start = rx_byte == start_byte;
    stat.len_too_big = rx_byte > {3'b000, limit};
    stat.len_zero = frame_length == 5'd0;
    stat.data_done = count_inc >= frame_length;
    stat.check_match = rx_byte == running_check;
    stat.emit_last = ({1'b0, rd_idx} + 5'd1) == frame_length;
    good_frames_next = good_frames;
    bad_frames_next = bad_frames;
    load = 1'b0;
    case (op)
      OP_LEN_BAD, OP_CHECK_BAD: begin
        bad_frames_next = bad_frames + 16'd1;
        load = 1'b1;
      end
      OP_GOOD_EMPTY: begin
        good_frames_next = good_frames + 16'd1;
        load = 1'b1;
      end
      OP_GOOD_BURST: begin
        good_frames_next = good_frames + 16'd1;
      end
      OP_EMIT: begin
        load = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      max_len <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_MAX_LEN: max_len <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= 5'd0;
      frame_command <= 8'd0;
      payload_count <= 5'd0;
      running_check <= 8'd0;
      good_frames <= 16'd0;
      bad_frames <= 16'd0;
      rd_idx <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      good_frames <= good_frames_next;
      bad_frames <= bad_frames_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (op)
        OP_START: begin
          running_check <= 8'd0;
        end
        OP_LEN_OK: begin
          frame_length <= rx_byte[4:0];
          running_check <= rx_byte;
        end
        OP_CMD: begin
          frame_command <= rx_byte;
          running_check <= running_check ^ rx_byte;
          payload_count <= 5'd0;
        end
        OP_DATA: begin
          running_check <= running_check ^ rx_byte;
          payload_count <= count_inc;
        end
        OP_GOOD_BURST: begin
          rd_idx <= 4'd0;
        end
        OP_EMIT: begin
          rd_idx <= rd_idx + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_DATA && payload_count < LEN_CAP) begin
      store[payload_count[ADDR_W-1:0]] <= rx_byte;
    end
    rd_data <= store[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_good <= good_frames_next;
      out_error <= bad_frames_next;
      out_last <= 1'b1;
      out_index <= 4'd0;
      out_payload <= 8'd0;
      out_has_payload <= 1'b0;
      out_command <= frame_command;
      out_length <= frame_length;
      out_check <= running_check;
      case (op)
        OP_LEN_BAD: begin
          out_status <= STAT_BAD_LEN;
          out_command <= 8'd0;
          out_length <= (rx_byte > 8'd31) ? 5'd31 : rx_byte[4:0];
          out_check <= 8'd0;
        end
        OP_CHECK_BAD: begin
          out_status <= STAT_BAD_CHECK;
        end
        OP_GOOD_EMPTY: begin
          out_status <= STAT_GOOD;
        end
        default: begin
          out_status <= STAT_GOOD;
          out_index <= rd_idx;
          out_payload <= rd_data;
          out_has_payload <= 1'b1;
          out_last <= stat.emit_last;
        end
      endcase
    end
  end

  assign m_tdata = {7'b0000000, out_error, out_good, out_check, out_payload, out_index,
                    out_length, out_command};
  assign m_tuser = {out_has_payload, out_status};
  assign m_tlast = out_last;

endmodule

// ===== design/xor_checked_frame_parser_top.sv =====
// Received bytes: one item per cycle while the result register is free.
// Length errors, check errors and empty frames give their result in the cycle after the byte is taken.
// A good frame with N payload bytes gives N results after the check byte; for each, a
// fetch state reads the registered payload store and an emit state loads the result
// register, waiting while it is still full; no bytes are taken during that readout.
// Synchronous reset clears counters and the parser and sets start_byte to 170 and max_len to 15.
`include "xor_checked_frame_parser_top_defines.svh"

module xor_checked_frame_parser_top
  import xcfp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // command, length, byte_index, payload_byte, expected_check,
  // good_count, error_count, zero padding
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,   // status, has_payload
  output logic                  m_tlast
);

  op_t      op;
  dp_stat_t stat;
  state_t   state;

  xcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .op       (op),
    .state    (state)
  );

  xcfp_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (s_tdata),
    .op        (op),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  `XCFP_ASSERT_SAME(a_no_input_in_readout, (state == ST_FETCH || state == ST_EMIT), !s_tready)
  `XCFP_ASSERT_SAME(a_ready_needs_free_out, s_tready, (!m_tvalid || m_tready))
  `XCFP_ASSERT_SAME(a_payload_only_good, (m_tvalid && m_tuser[2]), (m_tuser[1:0] == STAT_GOOD))
  `XCFP_ASSERT_NEXT(a_burst_starts_fetch, (op == OP_GOOD_BURST), (state == ST_FETCH))

endmodule

// ===== tb/xor_checked_frame_parser_top_tb.sv =====
// Self-checking testbench for xor_checked_frame_parser_top.
// Depends on xcfp_pkg and the parser RTL; a scoreboard class predicts every result item.
module xor_checked_frame_parser_top_tb
  import xcfp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [4:0]  length;
    logic [3:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic [7:0]  exp_check;
    logic        last;
    logic [15:0] good_count;
    logic [15:0] error_count;
  } frame_result_t;

  class frame_checker;
    logic [7:0]  start_val;
    logic [4:0]  max_len_val;
    state_t      phase;
    logic [4:0]  frame_len;
    logic [4:0]  pay_cnt;
    logic [7:0]  frame_cmd;
    logic [7:0]  run_chk;
    logic [7:0]  payload_mem [16];
    logic [15:0] good_cnt;
    logic [15:0] err_cnt;
    frame_result_t pending_results[$];
    int mismatches;
    int bytes_taken;
    int results_seen;
    int status_seen[3];

    function new();
      start_val = START_BYTE_RST;
      max_len_val = MAX_LEN_RST;
      phase = ST_START;
      frame_len = '0;
      pay_cnt = '0;
      frame_cmd = '0;
      run_chk = '0;
      good_cnt = '0;
      err_cnt = '0;
      foreach (payload_mem[i]) payload_mem[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_START_BYTE) start_val = data;
      else if (idx == REG_MAX_LEN) max_len_val = data[4:0];
    endfunction

    function void push_result(logic [1:0] st, logic [7:0] cmd, logic [4:0] len,
                              logic [3:0] idx, logic [7:0] pb, logic hp,
                              logic [7:0] chk, logic lst);
      frame_result_t r;
      r = '{st, cmd, len, idx, pb, hp, chk, lst, good_cnt, err_cnt};
      pending_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      int lim;
      lim = (max_len_val > 16) ? 16 : max_len_val;
      bytes_taken++;
      case (phase)
        ST_START: begin
          if (b == start_val) begin
            phase = ST_LEN;
            run_chk = '0;
          end
        end
        ST_LEN: begin
          if (b > lim) begin
            err_cnt++;
            phase = ST_START;
            push_result(STAT_BAD_LEN, 8'd0, (b > 31) ? 5'd31 : b[4:0], 4'd0, 8'd0, 1'b0,
                        8'd0, 1'b1);
          end else begin
            frame_len = b[4:0];
            run_chk = b;
            phase = ST_CMD;
          end
        end
        ST_CMD: begin
          frame_cmd = b;
          run_chk ^= b;
          pay_cnt = '0;
          phase = (frame_len == 0) ? ST_CHECK : ST_DATA;
        end
        ST_DATA: begin
          if (pay_cnt < 16) payload_mem[pay_cnt[3:0]] = b;
          run_chk ^= b;
          pay_cnt++;
          if (pay_cnt >= frame_len) phase = ST_CHECK;
        end
        ST_CHECK: begin
          if (b == run_chk) begin
            good_cnt++;
            if (frame_len == 0) begin
              push_result(STAT_GOOD, frame_cmd, 5'd0, 4'd0, 8'd0, 1'b0, run_chk, 1'b1);
            end else begin
              for (int i = 0; i < frame_len; i++)
                push_result(STAT_GOOD, frame_cmd, frame_len, i[3:0], payload_mem[i], 1'b1,
                            run_chk, (i + 1 == frame_len));
            end
          end else begin
            err_cnt++;
            push_result(STAT_BAD_CHECK, frame_cmd, frame_len, 4'd0, 8'd0, 1'b0, run_chk, 1'b1);
          end
          phase = ST_START;
        end
        default: phase = ST_START;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task cmp(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                         results_seen, name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u, logic l);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result item, tdata 0x%0h tuser 0x%0h", d, u));
      end else begin
        want = pending_results.pop_front();
        if (want.status <= STAT_BAD_CHECK) status_seen[want.status]++;
        cmp("status", u[1:0], want.status);
        cmp("has_payload", u[2], want.has_payload);
        cmp("command", d[7:0], want.command);
        cmp("length", d[12:8], want.length);
        cmp("byte_index", d[16:13], want.byte_index);
        cmp("payload_byte", d[24:17], want.payload_byte);
        cmp("expected_check", d[32:25], want.exp_check);
        cmp("good_count", d[48:33], want.good_count);
        cmp("error_count", d[64:49], want.error_count);
        cmp("last", l, want.last);
      end
      results_seen++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  frame_checker sb = new();
  int burst_left = 0;
  int bytes_sent = 0;
  logic [7:0] cur_start = START_BYTE_RST;
  logic [4:0] cur_max = MAX_LEN_RST;
  logic [15:0] ready_pat = '1;
  int pat_left = 0;

  xor_checked_frame_parser_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls on a rotating pattern that is reloaded whenever its down counter runs out.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    if (pat_left == 0) begin
      pat_left = 24;
      ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    m_tready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    pat_left--;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // keep limits how many bytes of the frame go out; a keep below the frame size leaves a broken frame.
  task automatic send_frame(input int len, input bit bad_check, input int keep);
    logic [7:0] frame_q[$];
    logic [7:0] cmd;
    logic [7:0] chk;
    logic [7:0] pb;
    int lim;
    lim = (cur_max > 16) ? 16 : cur_max;
    cmd = 8'($urandom_range(0, 255));
    frame_q = {cur_start, len[7:0]};
    if (len <= lim) begin
      chk = len[7:0] ^ cmd;
      frame_q.push_back(cmd);
      for (int i = 0; i < len; i++) begin
        pb = 8'($urandom_range(0, 255));
        chk ^= pb;
        frame_q.push_back(pb);
      end
      if (bad_check) chk ^= 8'h01 << $urandom_range(0, 7);
      frame_q.push_back(chk);
    end
    while (frame_q.size() > keep) void'(frame_q.pop_back());
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    if (idx == REG_START_BYTE) cur_start = data;
    else cur_max = data[4:0];
    @(posedge clk);
  endtask

  task automatic run_setting(input logic [7:0] start, input logic [7:0] max_data, input int n);
    int lim;
    int len;
    int kind;
    int target;
    drain();
    write_cfg(REG_START_BYTE, start);
    write_cfg(REG_MAX_LEN, max_data);
    lim = (cur_max > 16) ? 16 : cur_max;
    send_frame(lim, 1'b0, 99);
    send_frame(lim + 1, 1'b0, 99);
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        len = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 255);
        send_frame(len, 1'b0, 99);
      end else begin
        len = ($urandom_range(0, 4) == 0) ? lim : $urandom_range(0, (lim < 4) ? lim : 4);
        if (kind < 78) send_frame(len, 1'b0, 99);
        else if (kind < 88) send_frame(len, 1'b1, 99);
        else if (kind < 95) send_frame(len, 1'b0, $urandom_range(1, len + 3));
        else send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: noise, empty frame, oversize and saturated lengths,
    // a check mismatch, and start bytes used as command and payload.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA); send_byte(8'h00); send_byte(8'h5A); send_byte(8'h5A);
    send_byte(8'hAA); send_byte(8'h10);
    send_byte(8'hAA); send_byte(8'hFF);
    send_byte(8'hAA); send_byte(8'h01); send_byte(8'h33); send_byte(8'h44);
    send_byte(8'h00);
    send_byte(8'hAA); send_byte(8'h02); send_byte(8'hAA); send_byte(8'hAA);
    send_byte(8'hAA); send_byte(8'hA8);

    run_setting(8'h00, 8'h10, 19);
    run_setting(8'hFF, 8'h00, 19);
    run_setting(8'h3C, 8'hFF, 19);
    run_setting(8'h81, 8'hE5, 19);
    run_setting(8'hAA, 8'h0F, 19);
    drain();
    repeat (20) @(posedge clk);

    $display("Frame parser run: %0d bytes in, %0d results (%0d good, %0d length, %0d check).",
             bytes_sent, sb.results_seen, sb.status_seen[STAT_GOOD],
             sb.status_seen[STAT_BAD_LEN], sb.status_seen[STAT_BAD_CHECK]);
    $display("Six start/limit settings incl. limits 0 and 16; %0d mismatches, %0d left waiting.",
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results still waiting.", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== xor_checked_frame_parser_top.f =====
+incdir+design
design/xcfp_pkg.sv
design/xcfp_ctrl.sv
design/xcfp_dp.sv
design/xor_checked_frame_parser_top.sv
tb/xor_checked_frame_parser_top_tb.sv
